### hdl/u8nh_pkg.sv
// shared types and constants for the utf-8 word normalize and hash unit
// holds the queue entry layout between the decode front end and the hash back end
// no dependencies
`default_nettype none

package u8nh_pkg;

  // what a decoded code point asks of the back end
  typedef enum logic [1:0] {
    KIND_SPACE  = 2'd0,
    KIND_LETTER = 2'd1,
    KIND_JOINER = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  // one queue entry: kind plus the utf-8 encoding, first byte in the top bits
  typedef struct packed {
    kind_t       kind;
    logic [2:0]  nbytes;
    logic [31:0] bytes;
  } entry_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

endpackage

`default_nettype wire

### hdl/utf8_word_normalize_and_hash_unit.sv
// top level of the utf-8 word normalize and hash unit
// instantiates u8nh_front, u8nh_fifo and u8nh_back; uses u8nh_pkg
//
//  channel   handshake            payload
//  input     push / full          in_byte
//  result    empty / pop          key_length, primary_hash, secondary_hash
//  config    cfg_we               cfg_wdata (out_capacity)
//
// the front end takes one byte a cycle while the entry queue has room
// the back end takes one queue entry at a time in idle, then hashes its bytes, an owed space first
// a finished word waits in the result register; the queue keeps filling meanwhile
// synchronous active-high reset; out_capacity resets to 128, no clearing pass
`default_nettype none

module utf8_word_normalize_and_hash_unit #(
  parameter int MAX_CAPACITY = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       key_length,
  output logic [31:0]      primary_hash,
  output logic [31:0]      secondary_hash,
  input  wire logic        cfg_we,
  input  wire logic [8:0]  cfg_wdata
);
  import u8nh_pkg::*;

  localparam int          CAP_LIMIT   = (MAX_CAPACITY < 256) ? MAX_CAPACITY : 256;
  localparam logic [8:0]  CAP_LIMIT_W = 9'(CAP_LIMIT);

  logic [8:0] out_capacity;
  logic [8:0] cap;
  logic       take;
  logic       f_push, q_valid, q_pop;
  entry_t     f_entry, q_entry;

  assign take = push && !full;
  assign cap  = (out_capacity > CAP_LIMIT_W) ? CAP_LIMIT_W : out_capacity;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) out_capacity <= 9'd128;
    else if (cfg_we) out_capacity <= cfg_wdata;
  end

  u8nh_front u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_byte (in_byte),
    .q_entry (f_entry),
    .q_push  (f_push)
  );

  u8nh_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (f_push),
    .wr_data   (f_entry),
    .rd_en     (q_pop),
    .rd_data   (q_entry),
    .full      (full),
    .not_empty (q_valid)
  );

  u8nh_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cap            (cap),
    .q_valid        (q_valid),
    .q_entry        (q_entry),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .key_length     (key_length),
    .primary_hash   (primary_hash),
    .secondary_hash (secondary_hash)
  );

endmodule

`default_nettype wire

### hdl/u8nh_front.sv
// decode front end: utf-8 decoder, case folding and classification
// turns each accepted byte into at most one queue entry; uses u8nh_pkg
`default_nettype none

module u8nh_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            take,
  input  wire logic [7:0]      in_byte,
  output u8nh_pkg::entry_t     q_entry,
  output logic                 q_push
);
  import u8nh_pkg::*;

  localparam logic [20:0] CP_RSQUO = 21'h2019;
  localparam logic [20:0] CP_NNBSP = 21'h202F;
  localparam logic [20:0] CP_NBSP  = 21'h00A0;

  // latin and cyrillic capitals to lower case
  function automatic logic [20:0] fold(input logic [20:0] cp);
    logic [20:0] r;
    r = cp;
    if (cp >= 21'h41 && cp <= 21'h5A) r = cp + 21'h20;
    else if ((cp >= 21'hC0 && cp <= 21'hD6) || (cp >= 21'hD8 && cp <= 21'hDE)) r = cp + 21'h20;
    else if (cp >= 21'h410 && cp <= 21'h42F) r = cp + 21'h20;
    else if (cp == 21'h401) r = 21'h451;
    else if (cp == 21'h404) r = 21'h454;
    else if (cp == 21'h406) r = 21'h456;
    else if (cp == 21'h407) r = 21'h457;
    else if (cp == 21'h490) r = 21'h491;
    return r;
  endfunction

  logic [20:0] acc, acc_next;
  logic [1:0]  left, left_next;
  logic        emit_cp;
  logic        is_end;
  logic [20:0] cp_raw;
  logic [20:0] cp;
  logic        cp_space, cp_letter, cp_joiner;

  // decoder step for the byte on the input
  always_comb begin
    acc_next  = acc;
    left_next = left;
    emit_cp   = 1'b0;
    is_end    = 1'b0;
    cp_raw    = {13'b0, in_byte};
    if (left != 2'd0 && in_byte[7:6] == 2'b10) begin
      acc_next  = {acc[14:0], in_byte[5:0]};
      left_next = left - 2'd1;
      if (left == 2'd1) begin
        emit_cp = 1'b1;
        cp_raw  = {acc[14:0], in_byte[5:0]};
      end
    end else begin
      // a broken sequence yields no entry, like the replacement char, which is never kept
      left_next = 2'd0;
      if (in_byte == 8'h00) begin
        is_end   = 1'b1;
        acc_next = '0;
      end else if (!in_byte[7]) begin
        emit_cp = 1'b1;
      end else if (in_byte[7:5] == 3'b110) begin
        acc_next  = {16'b0, in_byte[4:0]};
        left_next = 2'd1;
      end else if (in_byte[7:4] == 4'b1110) begin
        acc_next  = {17'b0, in_byte[3:0]};
        left_next = 2'd2;
      end else if (in_byte[7:3] == 5'b11110) begin
        acc_next  = {18'b0, in_byte[2:0]};
        left_next = 2'd3;
      end
    end
  end

  // classify the folded code point
  always_comb begin
    cp        = fold(cp_raw);
    cp_space  = (cp == 21'h20) || (cp == 21'h09) || (cp == 21'h0D) || (cp == 21'h0A) ||
                (cp == CP_NBSP) || (cp == CP_NNBSP);
    cp_letter = (cp >= 21'h30 && cp <= 21'h39) || (cp >= 21'h61 && cp <= 21'h7A) ||
                (cp >= 21'hC0 && cp <= 21'h2AF) || (cp >= 21'h400 && cp <= 21'h52F);
    cp_joiner = (cp == 21'h2D) || (cp == 21'h27) || (cp == CP_RSQUO);
  end

  // entry build: kind and utf-8 encoding
  always_comb begin
    q_push = take && (is_end || (emit_cp && (cp_space || cp_letter || cp_joiner)));
    if (is_end)         q_entry.kind = KIND_END;
    else if (cp_space)  q_entry.kind = KIND_SPACE;
    else if (cp_letter) q_entry.kind = KIND_LETTER;
    else                q_entry.kind = KIND_JOINER;
    if (cp <= 21'h7F) begin
      q_entry.nbytes = 3'd1;
      q_entry.bytes  = {cp[7:0], 24'b0};
    end else if (cp <= 21'h7FF) begin
      q_entry.nbytes = 3'd2;
      q_entry.bytes  = {3'b110, cp[10:6], 2'b10, cp[5:0], 16'b0};
    end else if (cp <= 21'hFFFF) begin
      q_entry.nbytes = 3'd3;
      q_entry.bytes  = {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'b0};
    end else begin
      q_entry.nbytes = 3'd4;
      q_entry.bytes  = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                        2'b10, cp[5:0]};
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      left <= 2'd0;
    end else if (take) begin
      acc  <= acc_next;
      left <= left_next;
    end
  end

endmodule

`default_nettype wire

### hdl/u8nh_fifo.sv
// short queue of decoded entries between front and back end
// register based, depth from u8nh_pkg
`default_nettype none

module u8nh_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire u8nh_pkg::entry_t wr_data,
  input  wire logic             rd_en,
  output u8nh_pkg::entry_t      rd_data,
  output logic                  full,
  output logic                  not_empty
);
  import u8nh_pkg::*;

  entry_t                store [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]     count;
  logic                  do_wr, do_rd;

  assign full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;
  assign rd_data   = store[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) store[wr_ptr] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + QUEUE_AW'(1);
      if (do_rd) rd_ptr <= rd_ptr + QUEUE_AW'(1);
      if (do_wr && !do_rd) count <= count + (QUEUE_AW+1)'(1);
      else if (do_rd && !do_wr) count <= count - (QUEUE_AW+1)'(1);
    end
  end

endmodule

`default_nettype wire

### hdl/u8nh_back.sv
// hash back end: capacity check, space insertion, one byte of fnv-1a and djb2-xor a cycle
// holds the word state and the result register; uses u8nh_pkg
`default_nettype none

module u8nh_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [8:0]       cap,
  input  wire logic             q_valid,
  input  wire u8nh_pkg::entry_t q_entry,
  output logic                  q_pop,
  input  wire logic             pop,
  output logic                  empty,
  output logic [7:0]            key_length,
  output logic [31:0]           primary_hash,
  output logic [31:0]           secondary_hash
);
  import u8nh_pkg::*;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_MULT  = 32'd16777619;
  localparam logic [31:0] DJB_BASIS = 32'd5381;
  localparam logic [31:0] DJB_MULT  = 32'd33;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_HASH = 2'b10
  } state_t;

  state_t      state;
  logic        word_started, space_pending, halted;
  logic [7:0]  out_length, kept_length;
  logic [31:0] running_fnv, kept_fnv, running_djb, kept_djb;
  logic [31:0] shift;
  logic [2:0]  cnt;
  logic        with_space, cur_letter;
  logic        out_valid;

  logic        is_letter, need_space, skip, end_ready;
  logic [9:0]  total;
  logic [7:0]  hash_byte;
  logic [31:0] fnv_step, djb_step;

  // entry decisions in idle
  always_comb begin
    is_letter  = (q_entry.kind == KIND_LETTER);
    need_space = space_pending && is_letter;
    total      = {2'b0, out_length} + {7'b0, q_entry.nbytes} + {9'b0, need_space};
    skip       = halted || (q_entry.kind == KIND_JOINER && !word_started);
    end_ready  = !out_valid || pop;
    q_pop      = (state == ST_IDLE) && q_valid && (q_entry.kind != KIND_END || end_ready);
  end

  // one hash byte
  always_comb begin
    hash_byte = with_space ? 8'h20 : shift[31:24];
    fnv_step  = 32'((running_fnv ^ {24'b0, hash_byte}) * FNV_MULT);
    djb_step  = 32'(running_djb * DJB_MULT) ^ {24'b0, hash_byte};
  end

  assign empty          = !out_valid;

  // word state, hash engine and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      word_started  <= 1'b0;
      space_pending <= 1'b0;
      halted        <= 1'b0;
      out_length    <= '0;
      kept_length   <= '0;
      running_fnv   <= FNV_BASIS;
      kept_fnv      <= FNV_BASIS;
      running_djb   <= DJB_BASIS;
      kept_djb      <= DJB_BASIS;
      cnt           <= '0;
      with_space    <= 1'b0;
    end else begin
      // result register fill and drain
      if (q_pop && q_entry.kind == KIND_END) out_valid <= 1'b1;
      else if (pop && out_valid) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            case (q_entry.kind)
              KIND_END: begin
                key_length     <= kept_length;
                primary_hash   <= kept_fnv;
                secondary_hash <= kept_djb;
                word_started   <= 1'b0;
                space_pending  <= 1'b0;
                halted         <= 1'b0;
                out_length     <= '0;
                kept_length    <= '0;
                running_fnv    <= FNV_BASIS;
                kept_fnv       <= FNV_BASIS;
                running_djb    <= DJB_BASIS;
                kept_djb       <= DJB_BASIS;
              end
              KIND_SPACE: begin
                if (!halted) space_pending <= word_started;
              end
              default: begin
                if (!skip) begin
                  if (total >= {1'b0, cap}) begin
                    halted <= 1'b1;
                  end else begin
                    state        <= ST_HASH;
                    shift        <= q_entry.bytes;
                    cnt          <= q_entry.nbytes;
                    with_space   <= need_space;
                    cur_letter   <= is_letter;
                    out_length   <= total[7:0];
                    word_started <= 1'b1;
                    if (need_space) space_pending <= 1'b0;
                  end
                end
              end
            endcase
          end
        end
        ST_HASH: begin
          running_fnv <= fnv_step;
          running_djb <= djb_step;
          if (with_space) begin
            with_space <= 1'b0;
          end else begin
            shift <= {shift[23:0], 8'b0};
            cnt   <= cnt - 3'd1;
            if (cnt == 3'd1) begin
              state <= ST_IDLE;
              if (cur_letter) begin
                kept_length <= out_length;
                kept_fnv    <= fnv_step;
                kept_djb    <= djb_step;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a halted word never starts hashing a code point
  a_no_hash_when_halted: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HASH) |-> !halted)
    else $error("hash engine busy on a halted word");

  // the kept prefix never runs past the appended length
  a_kept_within_length: assert property (@(posedge clk) disable iff (rst)
    kept_length <= out_length)
    else $error("kept length beyond appended length");

  // nothing is appended before the first letter
  a_empty_until_started: assert property (@(posedge clk) disable iff (rst)
    !word_started |-> (out_length == '0 && kept_fnv == FNV_BASIS))
    else $error("bytes appended before word start");

  // a code point in progress always has bytes left
  a_hash_count_live: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HASH) |-> (cnt != 3'd0))
    else $error("hash engine with no bytes left");

endmodule

`default_nettype wire

### tb/testbench.sv
// self-checking testbench for utf8_word_normalize_and_hash_unit
// a queue-fed driver, a result monitor and a built-in normalizer and hash predictor
// depends only on the rtl top level, no package types needed at the ports
`default_nettype none

module testbench;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 6;
  localparam int NUM_PHASES    = 11;
  localparam int PHASE_BYTES   = 120;
  localparam int SETTLE_CYCLES = 40;
  localparam int WATCHDOG_MAX  = 5000;
  localparam int MAX_CAP       = 256;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_MULT  = 32'd16777619;
  localparam logic [31:0] DJB_BASIS = 32'd5381;
  localparam logic [31:0] DJB_MULT  = 32'd33;

  localparam logic [20:0] CP_TAB     = 21'h09;
  localparam logic [20:0] CP_LF      = 21'h0A;
  localparam logic [20:0] CP_CR      = 21'h0D;
  localparam logic [20:0] CP_SPACE   = 21'h20;
  localparam logic [20:0] CP_APOS    = 21'h27;
  localparam logic [20:0] CP_DASH    = 21'h2D;
  localparam logic [20:0] CP_NBSP    = 21'hA0;
  localparam logic [20:0] CP_RSQUO   = 21'h2019;
  localparam logic [20:0] CP_NNBSP   = 21'h202F;
  localparam logic [20:0] CP_REPLACE = 21'hFFFD;
  localparam logic [8:0]  CAP_RESET  = 9'd128;

  typedef struct packed {
    logic [7:0]  len;
    logic [31:0] fnv;
    logic [31:0] djb;
  } word_key_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_byte = 8'd0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  key_length;
  logic [31:0] primary_hash;
  logic [31:0] secondary_hash;
  logic        cfg_we = 1'b0;
  logic [8:0]  cfg_wdata = 9'd0;

  utf8_word_normalize_and_hash_unit uut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .in_byte        (in_byte),
    .empty          (empty),
    .pop            (pop),
    .key_length     (key_length),
    .primary_hash   (primary_hash),
    .secondary_hash (secondary_hash),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always #(HALF_PERIOD) clk = ~clk;

  logic [7:0] pending_bytes[$];
  word_key_t  expected_keys[$];
  int         error_count = 0;
  int         words_checked = 0;
  int         bytes_sent = 0;
  int         halted_words = 0;
  int         settings_used = 1;

  // predictor state: decoder, word builder and running hashes
  logic [8:0]  capacity = CAP_RESET;
  logic [20:0] cp_acc;
  logic [1:0]  cont_left;
  logic        started;
  logic        space_owed;
  logic        halted;
  logic [7:0]  out_len;
  logic [7:0]  kept_len;
  logic [31:0] run_fnv;
  logic [31:0] kept_fnv;
  logic [31:0] run_djb;
  logic [31:0] kept_djb;

  task automatic report_error(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic void clear_word();
    cp_acc     = '0;
    cont_left  = '0;
    started    = 1'b0;
    space_owed = 1'b0;
    halted     = 1'b0;
    out_len    = '0;
    kept_len   = '0;
    run_fnv    = FNV_BASIS;
    kept_fnv   = FNV_BASIS;
    run_djb    = DJB_BASIS;
    kept_djb   = DJB_BASIS;
  endfunction

  // utf-8 encoding, first byte in the top bits
  function automatic void utf8_encode(input logic [20:0] c, output logic [31:0] enc,
                                      output int n);
    if (c <= 21'h7F) begin
      enc = {c[7:0], 24'h0};
      n = 1;
    end else if (c <= 21'h7FF) begin
      enc = {3'b110, c[10:6], 2'b10, c[5:0], 16'h0};
      n = 2;
    end else if (c <= 21'hFFFF) begin
      enc = {4'b1110, c[15:12], 2'b10, c[11:6], 2'b10, c[5:0], 8'h0};
      n = 3;
    end else begin
      enc = {5'b11110, c[20:18], 2'b10, c[17:12], 2'b10, c[11:6], 2'b10, c[5:0]};
      n = 4;
    end
  endfunction

  // latin and cyrillic capitals to lower case
  function automatic logic [20:0] fold_case(logic [20:0] c);
    if (c >= 21'h41 && c <= 21'h5A) return c + 21'h20;
    if ((c >= 21'hC0 && c <= 21'hD6) || (c >= 21'hD8 && c <= 21'hDE)) return c + 21'h20;
    if (c >= 21'h410 && c <= 21'h42F) return c + 21'h20;
    if (c == 21'h401) return 21'h451;
    if (c == 21'h404) return 21'h454;
    if (c == 21'h406) return 21'h456;
    if (c == 21'h407) return 21'h457;
    if (c == 21'h490) return 21'h491;
    return c;
  endfunction

  function automatic logic is_letter(logic [20:0] c);
    return (c >= 21'h30 && c <= 21'h39) || (c >= 21'h61 && c <= 21'h7A) ||
           (c >= 21'hC0 && c <= 21'h2AF) || (c >= 21'h400 && c <= 21'h52F);
  endfunction

  function automatic logic is_blank(logic [20:0] c);
    return c == CP_SPACE || c == CP_TAB || c == CP_CR || c == CP_LF ||
           c == CP_NBSP || c == CP_NNBSP;
  endfunction

  function automatic void hash_in(logic [7:0] b);
    run_fnv = (run_fnv ^ {24'h0, b}) * FNV_MULT;
    run_djb = (run_djb * DJB_MULT) ^ {24'h0, b};
  endfunction

  // append one decoded code point to the normalized word
  function automatic void absorb_cp(logic [20:0] raw);
    logic [20:0] c;
    logic        letter;
    logic        joiner;
    logic [31:0] enc;
    int          n;
    int          room;
    int          i;
    if (halted) return;
    c = fold_case(raw);
    if (is_blank(c)) begin
      space_owed = started;
      return;
    end
    letter = is_letter(c);
    joiner = started && (c == CP_DASH || c == CP_APOS || c == CP_RSQUO);
    if (!letter && !joiner) return;
    room = (capacity > MAX_CAP) ? MAX_CAP : int'(capacity);
    if (space_owed && letter) begin
      if (int'(out_len) + 1 >= room) begin
        halted = 1'b1;
        return;
      end
      hash_in(CP_SPACE[7:0]);
      out_len++;
      space_owed = 1'b0;
    end
    utf8_encode(c, enc, n);
    if (int'(out_len) + n >= room) begin
      halted = 1'b1;
      return;
    end
    for (i = 0; i < n; i++) hash_in(enc[31 - 8 * i -: 8]);
    out_len = out_len + 8'(n);
    started = 1'b1;
    if (letter) begin
      kept_len = out_len;
      kept_fnv = run_fnv;
      kept_djb = run_djb;
    end
  endfunction

  // decode one accepted byte; a zero byte queues the expected key
  function automatic void normalize_byte(logic [7:0] b);
    if (cont_left != 0) begin
      if (b[7:6] == 2'b10) begin
        cp_acc = {cp_acc[14:0], b[5:0]};
        cont_left--;
        if (cont_left == 0) absorb_cp(cp_acc);
        return;
      end
      cont_left = 0;
      absorb_cp(CP_REPLACE);
    end
    if (b == 8'h00) begin
      expected_keys.push_back('{len: kept_len, fnv: kept_fnv, djb: kept_djb});
      if (halted) halted_words++;
      clear_word();
    end else if (!b[7]) begin
      absorb_cp({13'd0, b});
    end else if (b[7:5] == 3'b110) begin
      cp_acc = {16'd0, b[4:0]};
      cont_left = 1;
    end else if (b[7:4] == 4'b1110) begin
      cp_acc = {17'd0, b[3:0]};
      cont_left = 2;
    end else if (b[7:3] == 5'b11110) begin
      cp_acc = {18'd0, b[2:0]};
      cont_left = 3;
    end else begin
      absorb_cp(CP_REPLACE);
    end
  endfunction

  // driver: present queued bytes with random gaps, predict on acceptance
  int   send_gap = 0;
  logic send_calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      send_gap = 0;
      clear_word();
    end else begin
      if (push && !full) begin
        normalize_byte(in_byte);
        bytes_sent++;
      end
      if (!push || !full) begin
        if (send_gap != 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_byte <= pending_bytes.pop_front();
          push <= 1'b1;
          if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
          send_gap = send_calm ? 0 : $urandom_range(0, 5);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: pop with random stalls, compare each word key with the oldest one
  int   sink_stall = 0;
  logic sink_calm = 1'b0;

  always @(posedge clk) begin
    logic      next_pop;
    word_key_t want;
    if (rst) begin
      pop <= 1'b0;
      sink_stall = 0;
    end else begin
      next_pop = pop;
      if (pop && !empty) begin
        if (expected_keys.size() == 0) begin
          report_error($sformatf("result with no word pending: len %0d", key_length));
        end else begin
          want = expected_keys.pop_front();
          words_checked++;
          if (key_length !== want.len)
            report_error($sformatf("word %0d key_length got %0d want %0d",
                                   words_checked, key_length, want.len));
          if (primary_hash !== want.fnv)
            report_error($sformatf("word %0d primary_hash got %h want %h",
                                   words_checked, primary_hash, want.fnv));
          if (secondary_hash !== want.djb)
            report_error($sformatf("word %0d secondary_hash got %h want %h",
                                   words_checked, secondary_hash, want.djb));
        end
        if ($urandom_range(0, 29) == 0) sink_calm = !sink_calm;
        sink_stall = sink_calm ? 0 : $urandom_range(0, 5);
        next_pop = (sink_stall == 0);
      end else if (!pop) begin
        if (sink_stall == 0) next_pop = 1'b1;
        else sink_stall--;
      end
      pop <= next_pop;
    end
  end

  // watchdog on cycles without any accepted word or byte
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("utf8_word_normalize_and_hash_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus helpers
  function automatic void add_cp(logic [20:0] c);
    logic [31:0] enc;
    int          n;
    int          i;
    utf8_encode(c, enc, n);
    for (i = 0; i < n; i++) pending_bytes.push_back(enc[31 - 8 * i -: 8]);
  endfunction

  function automatic void add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
  endfunction

  function automatic logic [20:0] pick_blank();
    case ($urandom_range(0, 5))
      0:       return CP_SPACE;
      1:       return CP_TAB;
      2:       return CP_CR;
      3:       return CP_LF;
      4:       return CP_NBSP;
      default: return CP_NNBSP;
    endcase
  endfunction

  function automatic logic [20:0] pick_joiner();
    case ($urandom_range(0, 2))
      0:       return CP_DASH;
      1:       return CP_APOS;
      default: return CP_RSQUO;
    endcase
  endfunction

  // one random piece of a word: mostly well-formed, some noise and broken sequences
  function automatic void add_token();
    int         k;
    int         i;
    logic [7:0] ch;
    k = $urandom_range(0, 99);
    if (k < 15)      add_cp(21'($urandom_range(8'h41, 8'h5A)));
    else if (k < 30) add_cp(21'($urandom_range(8'h61, 8'h7A)));
    else if (k < 37) add_cp(21'($urandom_range(8'h30, 8'h39)));
    else if (k < 47) add_cp(pick_blank());
    else if (k < 54) add_cp(pick_joiner());
    else if (k < 63) add_cp(21'($urandom_range(21'hC0, 21'h2FF)));
    else if (k < 72) add_cp(21'($urandom_range(21'h3F0, 21'h53F)));
    else if (k < 75) add_cp(21'($urandom_range(21'h80, 21'h7FF)));
    else if (k < 78) add_cp(21'($urandom_range(21'h800, 21'hFFFF)));
    else if (k < 80) add_cp(21'($urandom_range(21'h10000, 21'h1FFFFF)));
    else if (k < 85) add_cp(21'($urandom_range(1, 127)));
    else if (k < 88) begin
      // overlong two-byte form of an ascii code
      ch = 8'($urandom_range(1, 127));
      pending_bytes.push_back({6'b110000, ch[7:6]});
      pending_bytes.push_back({2'b10, ch[5:0]});
    end else if (k < 94) begin
      pending_bytes.push_back(8'($urandom_range(1, 255)));
    end else begin
      // a lead byte with up to two continuation bytes, often cut short by whatever follows
      pending_bytes.push_back(8'($urandom_range(8'hC0, 8'hF7)));
      for (i = $urandom_range(0, 2); i > 0; i--)
        pending_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
    end
  endfunction

  function automatic void add_random_word();
    int ntok;
    ntok = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 180) : $urandom_range(0, 8);
    repeat (ntok) add_token();
    pending_bytes.push_back(8'h00);
  endfunction

  // directed words: edges of folding, spacing, joiners, decoding and capacity
  function automatic void add_directed();
    // empty word
    pending_bytes.push_back(8'h00);
    // leading blanks and joiners dropped, blank run collapsed, trailing joiners trimmed
    add_text(" -Ab\t\r\n 9");
    add_cp(CP_NBSP);
    add_cp(CP_NNBSP);
    add_text("z-'");
    add_cp(CP_RSQUO);
    pending_bytes.push_back(8'h00);
    // latin and cyrillic folding, range edges, times sign kept as is
    add_cp(21'hC0);
    add_cp(21'hD7);
    add_cp(21'hDE);
    add_cp(21'h2AF);
    add_cp(21'h2B0);
    add_cp(21'h401);
    add_cp(21'h404);
    add_cp(21'h406);
    add_cp(21'h407);
    add_cp(21'h410);
    add_cp(21'h42F);
    add_cp(21'h490);
    add_cp(21'h52F);
    pending_bytes.push_back(8'h00);
    // stray continuation, invalid leads, bad continuation decoded again as a lead
    pending_bytes.push_back(8'h80);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'hF8);
    pending_bytes.push_back(8'hC3);
    add_text("B");
    // overlong 'A' and an out-of-range four-byte form
    pending_bytes.push_back(8'hC1);
    pending_bytes.push_back(8'h81);
    pending_bytes.push_back(8'hF7);
    pending_bytes.push_back(8'hBF);
    pending_bytes.push_back(8'hBF);
    pending_bytes.push_back(8'hBF);
    // truncated sequence ended by the terminator
    pending_bytes.push_back(8'hE2);
    pending_bytes.push_back(8'h80);
    pending_bytes.push_back(8'h00);
    // two-byte letters past the capacity, halting in the middle of the word
    repeat (70) add_cp(21'h416);
    pending_bytes.push_back(8'h00);
  endfunction

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || push || expected_keys.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [8:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    capacity = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // test sequence
  initial begin
    int          p;
    int          start_bytes;
    logic [8:0]  cap_plan[NUM_PHASES];
    cap_plan = '{CAP_RESET, 9'd0, 9'd1, 9'd2, 9'd511, 9'd256, 9'd3,
                 9'($urandom_range(4, 48)), 9'd300, 9'($urandom_range(0, 511)), CAP_RESET};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    for (p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        write_capacity(cap_plan[p]);
      end
      start_bytes = bytes_sent + pending_bytes.size();
      if (p == 0) add_directed();
      while (bytes_sent + pending_bytes.size() - start_bytes < PHASE_BYTES) add_random_word();
    end
    wait_idle();
    $display("checked %0d words from %0d bytes under %0d capacity settings",
             words_checked, bytes_sent, settings_used);
    $display("%0d words were cut short by the capacity", halted_words);
    if (error_count == 0) begin
      $display("utf8_word_normalize_and_hash_unit test passed");
    end else begin
      $display("%0d mismatches", error_count);
      $display("utf8_word_normalize_and_hash_unit test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
